### rtl/ranked_constraint_winner_select_top_defines.svh
// Assertion macros shared by the checker of the ranked constraint winner select block
`ifndef RANKED_CONSTRAINT_WINNER_SELECT_TOP_DEFINES_SVH
`define RANKED_CONSTRAINT_WINNER_SELECT_TOP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent
`define RCWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcws check failed");

// Consequent checked in the same cycle as the antecedent
`define RCWS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcws check failed");

`endif

### rtl/rcws_pkg.sv
// Package with widths, codes, state type and helpers of the winner select block
package rcws_pkg;

  localparam int MAX_CANDIDATES_DEF  = 16;
  localparam int MAX_CONSTRAINTS_DEF = 32;
  localparam int COUNT_BITS_DEF      = 8;

  localparam int FUNC_W   = 2;
  localparam int CAND_W   = 4;
  localparam int CON_W    = 5;
  localparam int SLOT_W   = 5;
  localparam int VCOUNT_W = 8;
  localparam int TOTAL_W  = 5;
  localparam int WIN_W    = 4;
  localparam int CTOT_W   = 6;

  localparam logic [CTOT_W-1:0] CTOT_RESET = 6'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_COUNT = 2'd0,
    FUNC_WR_RANK  = 2'd1,
    FUNC_EVAL     = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SLOT,
    ST_RANK_WAIT,
    ST_MIN_RD,
    ST_MIN_SURV,
    ST_MIN_CMP,
    ST_ELIM_RD,
    ST_ELIM_SURV,
    ST_ELIM_CMP,
    ST_SWAP_WAIT,
    ST_SWAP_WR,
    ST_FINISH,
    ST_RESULT
  } state_t;

  // Address width for a table of n entries, at least one bit
  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### rtl/rcws_if.sv
// Handshake interfaces for the item and result channels
interface rcws_in_if;
  logic                         valid;
  logic                         ready;
  logic [rcws_pkg::FUNC_W-1:0]   func;
  logic [rcws_pkg::CAND_W-1:0]   cand_index;
  logic [rcws_pkg::CON_W-1:0]    con_index;
  logic [rcws_pkg::SLOT_W-1:0]   rank_slot;
  logic [rcws_pkg::VCOUNT_W-1:0] violation_count;
  logic [rcws_pkg::TOTAL_W-1:0]  cand_total;

  modport source (
    output valid, func, cand_index, con_index, rank_slot, violation_count, cand_total,
    input  ready
  );
  modport sink (
    input  valid, func, cand_index, con_index, rank_slot, violation_count, cand_total,
    output ready
  );
endinterface

interface rcws_out_if;
  logic                      valid;
  logic                      ready;
  logic [rcws_pkg::WIN_W-1:0] winner;
  logic                      tie_left;

  modport source (
    output valid, winner, tie_left,
    input  ready
  );
  modport sink (
    input  valid, winner, tie_left,
    output ready
  );
endinterface

### rtl/rcws_ram.sv
// Generic single write port, single read port RAM with registered read data
module rcws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = rcws_pkg::addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ranked_constraint_winner_select_top.sv
// Top level of the ranked constraint winner select block
// Loads (count write, rank write, unused code) keep the block idle, so the next item is taken at once.
// Evaluate with R candidates fills the survivor list, then for each walked slot finds the least
// count among the survivors and removes each one above it, until one is left or the slots run out.
// Result sits in an output register; a new item is taken while it waits.
// Reset (rst_n, synchronous, active low) clears control, output valid and sets the
// constraint total to 32; count, rank and survivor RAMs are undefined until written.
module ranked_constraint_winner_select_top #(
  parameter int MAX_CANDIDATES  = rcws_pkg::MAX_CANDIDATES_DEF,
  parameter int MAX_CONSTRAINTS = rcws_pkg::MAX_CONSTRAINTS_DEF,
  parameter int COUNT_BITS      = rcws_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rcws_in_if.sink                     in_ch,
  rcws_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rcws_pkg::CTOT_W-1:0] cfg_wdata
);

  localparam int SW     = rcws_pkg::addr_w(MAX_CANDIDATES);
  localparam int RW     = $clog2(MAX_CANDIDATES + 1);
  localparam int RKW    = rcws_pkg::addr_w(MAX_CONSTRAINTS);
  localparam int SLW    = $clog2(MAX_CONSTRAINTS + 1);
  localparam int VDEPTH = MAX_CANDIDATES * MAX_CONSTRAINTS;
  localparam int VAW    = rcws_pkg::addr_w(VDEPTH);

  // Flat count address: candidate major, constraint minor
  function automatic logic [VAW-1:0] vaddr(input logic [31:0] cand, input logic [31:0] con);
    logic [31:0] a;
    a = cand * MAX_CONSTRAINTS + con;
    return a[VAW-1:0];
  endfunction

  rcws_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [RW-1:0]                 i_r, i_nxt;
  logic [SLW-1:0]                s_r, s_nxt;
  logic [SLW-1:0]                slots_r, slots_nxt;
  logic [rcws_pkg::CON_W-1:0]    con_r, con_nxt;
  logic [SW-1:0]                 cand_r, cand_nxt;
  logic [COUNT_BITS-1:0]         least_r, least_nxt;
  logic [rcws_pkg::CTOT_W-1:0]   cfg_total_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [rcws_pkg::WIN_W-1:0]    winner_r, winner_nxt;
  logic                          tie_r, tie_nxt;

  // RAM ports
  logic                          v_we, v_re;
  logic [VAW-1:0]                v_waddr, v_raddr;
  logic [COUNT_BITS-1:0]         v_wdata, v_rdata;
  logic                          k_we, k_re;
  logic [RKW-1:0]                k_waddr, k_raddr;
  logic [rcws_pkg::CON_W-1:0]    k_wdata, k_rdata;
  logic                          s_we, s_re;
  logic [SW-1:0]                 s_waddr, s_raddr;
  logic [SW-1:0]                 s_wdata, s_rdata;

  logic                          in_fire;
  logic                          con_ok;
  logic [COUNT_BITS-1:0]         cur_count;
  logic [RW-1:0]                 rem_init;
  logic [SLW-1:0]                slots_init;

  // Violation counts, candidate by constraint
  rcws_ram #(.WIDTH(COUNT_BITS), .DEPTH(VDEPTH)) u_viol_ram (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
  );

  // Constraint named in each rank slot
  rcws_ram #(.WIDTH(rcws_pkg::CON_W), .DEPTH(MAX_CONSTRAINTS)) u_rank_ram (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  // Survivor list; every access is sequenced by the FSM, so reads and writes
  // of the same entry never overlap and no forwarding is needed
  rcws_ram #(.WIDTH(SW), .DEPTH(MAX_CANDIDATES)) u_surv_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  assign in_ch.ready     = (state_r == rcws_pkg::ST_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.winner   = winner_r;
  assign out_ch.tie_left = tie_r;

  // A rank slot naming a missing constraint reads as count zero
  assign con_ok    = (32'(con_r) < MAX_CONSTRAINTS);
  assign cur_count = con_ok ? v_rdata : '0;

  // Clamp the candidate total to 1..MAX_CANDIDATES
  always_comb begin
    if (in_ch.cand_total == '0) begin
      rem_init = RW'(1);
    end else if (32'(in_ch.cand_total) > MAX_CANDIDATES) begin
      rem_init = RW'(MAX_CANDIDATES);
    end else begin
      rem_init = RW'(in_ch.cand_total);
    end
  end

  // Clamp the walked slot count to MAX_CONSTRAINTS
  always_comb begin
    if (32'(cfg_total_r) > MAX_CONSTRAINTS) begin
      slots_init = SLW'(MAX_CONSTRAINTS);
    end else begin
      slots_init = SLW'(cfg_total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcws_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_total_r <= rcws_pkg::CTOT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_total_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers hold their value unless the FSM moves them
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    i_r      <= i_nxt;
    s_r      <= s_nxt;
    slots_r  <= slots_nxt;
    con_r    <= con_nxt;
    cand_r   <= cand_nxt;
    least_r  <= least_nxt;
    winner_r <= winner_nxt;
    tie_r    <= tie_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    i_nxt         = i_r;
    s_nxt         = s_r;
    slots_nxt     = slots_r;
    con_nxt       = con_r;
    cand_nxt      = cand_r;
    least_nxt     = least_r;
    winner_nxt    = winner_r;
    tie_nxt       = tie_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    v_we    = 1'b0;
    v_waddr = vaddr(32'(in_ch.cand_index), 32'(in_ch.con_index));
    v_wdata = COUNT_BITS'(in_ch.violation_count);
    v_re    = 1'b0;
    v_raddr = vaddr(32'(s_rdata), 32'(con_r));
    k_we    = 1'b0;
    k_waddr = RKW'(in_ch.rank_slot);
    k_wdata = in_ch.con_index;
    k_re    = 1'b0;
    k_raddr = s_r[RKW-1:0];
    s_we    = 1'b0;
    s_waddr = i_r[SW-1:0];
    s_wdata = SW'(i_r);
    s_re    = 1'b0;
    s_raddr = i_r[SW-1:0];

    case (state_r)
      rcws_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.func)
            rcws_pkg::FUNC_WR_COUNT: begin
              // drop writes outside the table
              v_we = (32'(in_ch.cand_index) < MAX_CANDIDATES) &&
                     (32'(in_ch.con_index) < MAX_CONSTRAINTS);
            end
            rcws_pkg::FUNC_WR_RANK: begin
              k_we = (32'(in_ch.rank_slot) < MAX_CONSTRAINTS);
            end
            rcws_pkg::FUNC_EVAL: begin
              rem_nxt   = rem_init;
              slots_nxt = slots_init;
              i_nxt     = '0;
              s_nxt     = '0;
              state_nxt = rcws_pkg::ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      // fill the survivor list in index order, one entry a cycle
      rcws_pkg::ST_INIT: begin
        s_we = 1'b1;
        if (i_r == rem_r - RW'(1)) begin
          i_nxt     = '0;
          state_nxt = rcws_pkg::ST_SLOT;
        end else begin
          i_nxt = i_r + RW'(1);
        end
      end

      rcws_pkg::ST_SLOT: begin
        if (s_r == slots_r || rem_r < RW'(2)) begin
          state_nxt = rcws_pkg::ST_FINISH;
        end else begin
          k_re      = 1'b1;
          state_nxt = rcws_pkg::ST_RANK_WAIT;
        end
      end

      rcws_pkg::ST_RANK_WAIT: begin
        con_nxt   = k_rdata;
        least_nxt = '1;
        i_nxt     = '0;
        state_nxt = rcws_pkg::ST_MIN_RD;
      end

      // minimum pass: survivor, then its count
      rcws_pkg::ST_MIN_RD: begin
        s_re      = 1'b1;
        state_nxt = rcws_pkg::ST_MIN_SURV;
      end

      rcws_pkg::ST_MIN_SURV: begin
        v_re      = 1'b1;
        state_nxt = rcws_pkg::ST_MIN_CMP;
      end

      rcws_pkg::ST_MIN_CMP: begin
        if (cur_count < least_r) begin
          least_nxt = cur_count;
        end
        if (i_r == rem_r - RW'(1)) begin
          i_nxt     = '0;
          state_nxt = rcws_pkg::ST_ELIM_RD;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = rcws_pkg::ST_MIN_RD;
        end
      end

      // removal pass: swap each loser with the last survivor and retest
      rcws_pkg::ST_ELIM_RD: begin
        if (i_r == rem_r) begin
          s_nxt     = s_r + SLW'(1);
          state_nxt = rcws_pkg::ST_SLOT;
        end else begin
          s_re      = 1'b1;
          state_nxt = rcws_pkg::ST_ELIM_SURV;
        end
      end

      rcws_pkg::ST_ELIM_SURV: begin
        cand_nxt  = s_rdata;
        v_re      = 1'b1;
        state_nxt = rcws_pkg::ST_ELIM_CMP;
      end

      rcws_pkg::ST_ELIM_CMP: begin
        if (cur_count > least_r) begin
          rem_nxt   = rem_r - RW'(1);
          s_re      = 1'b1;
          s_raddr   = SW'(rem_r - RW'(1));
          state_nxt = rcws_pkg::ST_SWAP_WAIT;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = rcws_pkg::ST_ELIM_RD;
        end
      end

      rcws_pkg::ST_SWAP_WAIT: begin
        s_we      = 1'b1;
        s_wdata   = s_rdata;
        state_nxt = rcws_pkg::ST_SWAP_WR;
      end

      rcws_pkg::ST_SWAP_WR: begin
        s_we      = 1'b1;
        s_waddr   = SW'(rem_r);
        s_wdata   = cand_r;
        state_nxt = rcws_pkg::ST_ELIM_RD;
      end

      rcws_pkg::ST_FINISH: begin
        s_re      = 1'b1;
        s_raddr   = '0;
        state_nxt = rcws_pkg::ST_RESULT;
      end

      // hold the read data until the output register frees up
      rcws_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          winner_nxt    = rcws_pkg::WIN_W'(s_rdata);
          tie_nxt       = (rem_r > RW'(1));
          state_nxt     = rcws_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rcws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/rcws_checker.sv
// Port level checker of the ranked constraint winner select block, with its bind
`include "ranked_constraint_winner_select_top_defines.svh"

module rcws_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [rcws_pkg::FUNC_W-1:0] in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rcws_pkg::WIN_W-1:0]  out_winner,
  input logic                        out_tie_left
);

  `RCWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RCWS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_winner) && $stable(out_tie_left))
  `RCWS_ASSERT_NEXT(a_eval_busy, in_valid && in_ready && in_func == rcws_pkg::FUNC_EVAL, !in_ready)
  `RCWS_ASSERT_NEXT(a_load_ready, in_valid && in_ready && in_func != rcws_pkg::FUNC_EVAL, in_ready)
  `RCWS_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind ranked_constraint_winner_select_top rcws_checker u_rcws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_winner   (out_ch.winner),
  .out_tie_left (out_ch.tie_left)
);
